FILE: design/nfa_epsilon_stream_matcher_top_assert.svh
// Assertion macros for the automaton stream matcher.
// Used by nfa_epsilon_stream_matcher_top; no other dependencies.
`ifndef NFA_EPSILON_STREAM_MATCHER_TOP_ASSERT_SVH
`define NFA_EPSILON_STREAM_MATCHER_TOP_ASSERT_SVH
`ifndef SYNTH
`define NFA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define NFA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define NFA_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define NFA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: design/nfa_pkg.sv
// Shared types and constants for the automaton stream matcher.
// No dependencies.
package nfa_pkg;
    localparam int NumStates   = 32;
    localparam int SymbolCount = 256;
    localparam int StW         = $clog2(NumStates);
    localparam int SymW        = $clog2(SymbolCount);
    localparam int TrDepth     = NumStates * SymbolCount;
    localparam int TrAw        = $clog2(TrDepth);

    localparam logic [1:0] KIND_ADD_SYM = 2'd0;
    localparam logic [1:0] KIND_ADD_EPS = 2'd1;
    localparam logic [1:0] KIND_BEGIN   = 2'd2;
    localparam logic [1:0] KIND_SYMBOL  = 2'd3;

    localparam logic CFG_START  = 1'b0;
    localparam logic CFG_ACCEPT = 1'b1;

    typedef logic [NumStates-1:0] set_t;
endpackage

FILE: design/nfa_ram.sv
// Generic single port RAM with registered read.
// No dependencies.
module nfa_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: design/nfa_cell.sv
// One state cell: holds its epsilon row and passes the OR chain on.
// Depends on nfa_pkg.
module nfa_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                eps_we,
    input  nfa_pkg::set_t       eps_wdata,
    input  logic                act,
    input  nfa_pkg::set_t       or_in,
    output nfa_pkg::set_t       or_out
);
    nfa_pkg::set_t eps_reg;

    // epsilon row, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= '0;
        end else if (eps_we) begin
            eps_reg <= eps_reg | eps_wdata;
        end
    end

    // chain of ORs along the row
    assign or_out  = or_in | (act ? eps_reg : '0);
endmodule

FILE: design/nfa_epsilon_stream_matcher_top.sv
// Top level of the automaton stream matcher: sequencer, transition RAM,
// cell row for epsilon closure. Depends on nfa_pkg, nfa_ram, nfa_cell, assert header.
//
//  channel  direction  handshake
//  s_       in         s_valid / s_ready
//  m_       out        m_valid / m_ready
//  cfg      in         cfg_we, no wait
//
// Reset: clear pass over all 8192 transition RAM entries, s_ready low meanwhile.
// Loads: epsilon load is taken in ST_IDLE; symbol load is a read-modify-write (ST_TR_RD, ST_TR_WR).
// Begin: one closure pass per cycle until no change, 1 to 32 passes.
// Symbol: ST_MOVE sweeps the transition RAM rows of all NumStates states, then closure;
// a symbol while dead goes straight to ST_OUT.
// The result waits in an output register while new requests are taken; a finished
// result holds the sequencer only until that register frees.
`include "nfa_epsilon_stream_matcher_top_assert.svh"
module nfa_epsilon_stream_matcher_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [4:0]  s_from_state,
    input  logic [7:0]  s_symbol,
    input  logic [31:0] s_target_mask,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_active_set,
    output logic [4:0]  m_lowest_active,
    output logic        m_set_empty,
    output logic        m_accepting,
    output logic        m_dead,
    output logic [15:0] m_symbol_index,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int N = nfa_pkg::NumStates;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_TR_RD, ST_TR_WR, ST_MOVE, ST_CLOS, ST_OUT
    } state_t;

    state_t state_reg;
    logic [nfa_pkg::TrAw-1:0] clr_reg;
    logic [1:0]  kind_reg;
    logic [4:0]  from_reg;
    logic [7:0]  sym_reg;
    nfa_pkg::set_t tgt_reg, cur_reg, acc_reg;
    logic [nfa_pkg::StW:0] scan_reg;
    logic        dead_reg;
    logic [15:0] pos_reg;
    logic [4:0]  start_reg;
    logic [31:0] accept_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= '0;
            accept_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                nfa_pkg::CFG_START:  start_reg  <= cfg_data[4:0];
                nfa_pkg::CFG_ACCEPT: accept_reg <= cfg_data;
            endcase
        end
    end

    // transition RAM
    logic ram_we;
    logic [nfa_pkg::TrAw-1:0] ram_addr;
    nfa_pkg::set_t ram_wdata, ram_rdata;
    logic [nfa_pkg::StW-1:0] scan_st;
    logic [nfa_pkg::StW-1:0] prev_st;
    assign scan_st = scan_reg[nfa_pkg::StW-1:0];
    // state whose RAM data arrives this cycle
    assign prev_st = scan_st - 1'b1;

    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = ram_rdata | tgt_reg;
        ram_addr  = {from_reg[nfa_pkg::StW-1:0], sym_reg[nfa_pkg::SymW-1:0]};
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1; ram_addr = clr_reg; ram_wdata = '0;
            end
            ST_TR_WR: ram_we = 1'b1;
            ST_MOVE:  ram_addr = {scan_st, sym_reg[nfa_pkg::SymW-1:0]};
            default: ;
        endcase
    end

    nfa_ram #(.Width(N), .Depth(nfa_pkg::TrDepth)) u_tr (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    // cell row: epsilon rows and OR chain over the accumulator
    nfa_pkg::set_t chain [N+1];
    logic eps_load;
    assign eps_load = (state_reg == ST_IDLE) && s_valid
                    && (s_kind == nfa_pkg::KIND_ADD_EPS);
    assign chain[0] = acc_reg;
    for (genvar g = 0; g < N; g++) begin : g_cell
        nfa_cell u_cell (
            .aclk(aclk), .aresetn(aresetn),
            .eps_we(eps_load && (s_from_state == 5'(g))),
            .eps_wdata(s_target_mask),
            .act(acc_reg[g]), .or_in(chain[g]), .or_out(chain[g+1])
        );
    end

    logic [4:0] low;
    always_comb begin
        low = '0;
        for (int i = N-1; i >= 0; i--) begin
            if (acc_reg[i]) low = 5'(i);
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // output register is free when empty or emptied this cycle
    logic out_free, out_load;
    assign out_free = !m_valid || m_ready;
    assign out_load = out_free && ((state_reg == ST_OUT)
                    || ((state_reg == ST_CLOS) && (chain[N] == acc_reg)));

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            cur_reg   <= '0;
            dead_reg  <= 1'b0;
            pos_reg   <= '0;
            m_valid   <= 1'b0;
        end else begin
            if (out_load) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg) state_reg <= ST_IDLE;
                end
                ST_IDLE: if (s_valid) begin
                    kind_reg <= s_kind; from_reg <= s_from_state;
                    sym_reg <= s_symbol; tgt_reg <= s_target_mask;
                    scan_reg <= '0;
                    unique case (s_kind)
                        nfa_pkg::KIND_ADD_SYM: state_reg <= ST_TR_RD;
                        nfa_pkg::KIND_ADD_EPS: state_reg <= ST_IDLE;
                        nfa_pkg::KIND_BEGIN: begin
                            dead_reg <= 1'b0;
                            pos_reg  <= '0;
                            acc_reg  <= nfa_pkg::set_t'(1) << start_reg;
                            state_reg <= ST_CLOS;
                        end
                        default: begin
                            acc_reg <= '0;
                            state_reg <= dead_reg ? ST_OUT : ST_MOVE;
                        end
                    endcase
                end
                ST_TR_RD: state_reg <= ST_TR_WR;
                ST_TR_WR: state_reg <= ST_IDLE;
                ST_MOVE: begin
                    // RAM data for state scan-1 arrives now
                    if (scan_reg != '0 && cur_reg[prev_st]) begin
                        acc_reg <= acc_reg | ram_rdata;
                    end
                    scan_reg <= scan_reg + 1'b1;
                    if (scan_reg == (nfa_pkg::StW+1)'(N)) state_reg <= ST_CLOS;
                end
                ST_CLOS: begin
                    acc_reg <= chain[N];
                    if (out_load) begin
                        cur_reg <= acc_reg;
                        if (kind_reg == nfa_pkg::KIND_SYMBOL) begin
                            if (acc_reg == '0) dead_reg <= 1'b1;
                            else if (pos_reg != 16'hFFFF) pos_reg <= pos_reg + 1'b1;
                        end
                        m_active_set    <= acc_reg;
                        m_lowest_active <= low;
                        m_set_empty     <= (acc_reg == '0);
                        m_accepting     <= |(acc_reg & accept_reg);
                        m_dead          <= (kind_reg == nfa_pkg::KIND_SYMBOL)
                                           && (acc_reg == '0);
                        m_symbol_index  <= pos_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        // dead path: report held state
                        m_active_set <= '0; m_lowest_active <= '0; m_set_empty <= 1'b1;
                        m_accepting <= 1'b0; m_dead <= 1'b1; m_symbol_index <= pos_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `NFA_ASSERT_IMPL(a_dead_empty, aclk, aresetn, m_valid && m_dead, m_set_empty)
    `NFA_ASSERT_IMPL(a_empty_low, aclk, aresetn, m_valid && m_set_empty, m_lowest_active == 5'd0)
    `NFA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_active_set))
endmodule
